// ----- rtl/bemau_pkg.sv -----
// ----------------------------------------------------------------------------
// bemau_pkg: shared types and constants of the big-endian memory access unit
// Request and response payloads, sequencer states, register indexes and the
// byte swap used to turn big-endian byte order into lane order.
// ----------------------------------------------------------------------------
package bemau_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEMORY_LIMIT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CPU_MODEL_MAJOR = 1'b1;
    localparam int CFG_DATA_W = 17;

    // Reset values of the configuration registers.
    localparam logic [16:0] MEMORY_LIMIT_RST    = 17'h10000;
    localparam logic [2:0]  CPU_MODEL_MAJOR_RST = 3'd0;

    // CPU generations from this one on allow odd wide accesses.
    localparam logic [2:0] CPU_ODD_OK_MIN = 3'd2;

    // Request types and access sizes.
    localparam logic       REQ_READ  = 1'b0;
    localparam logic       REQ_WRITE = 1'b1;
    localparam logic [1:0] SIZE_BYTE = 2'd0;

    typedef struct packed {
        logic        req_type;
        logic [1:0]  access_size;
        logic [31:0] address;
        logic [63:0] write_data;
    } bemau_req_t;

    typedef struct packed {
        logic [63:0] read_data;
        logic        address_error;
        logic        fault_was_read;
        logic [31:0] fault_address;
    } bemau_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW1,
        ST_FIN
    } bemau_state_t;

    // Reverses the byte order of a 64-bit word.
    function automatic logic [63:0] byte_swap64(input logic [63:0] d);
        logic [63:0] r;
        r = '0;
        for (int k = 0; k < 8; k++) begin
            r[8*k +: 8] = d[8*(7-k) +: 8];
        end
        return r;
    endfunction

endpackage

// ----- rtl/bemau_ram.sv -----
// ----------------------------------------------------------------------------
// bemau_ram: single-port synchronous RAM with byte write enables
// One access per cycle; a read (enable with no byte enables set) registers
// its data, which then holds until the next read.
// ----------------------------------------------------------------------------
module bemau_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8192
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [WIDTH/8-1:0]         wbe,
    input  logic [$clog2(DEPTH)-1:0]   addr,
    input  logic [WIDTH-1:0]           wdata,
    output logic [WIDTH-1:0]           rdata
);

    localparam int NB = WIDTH / 8;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (|wbe) begin
                for (int b = 0; b < NB; b++) begin
                    if (wbe[b]) begin
                        mem[addr][8*b +: 8] <= wdata[8*b +: 8];
                    end
                end
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/big_endian_memory_access_unit_core.sv -----
// ----------------------------------------------------------------------------
// big_endian_memory_access_unit_core: big-endian byte memory of a 68000 bus
// Reads and writes 1, 2, 4 or 8 bytes at a byte address, checks the access
// against the configured memory size and raises address errors on odd wide
// accesses for early CPU generations.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake              Payload
//   s_        in         s_valid / s_ready      bemau_req_t   (one request)
//   m_        out        m_valid / m_ready      bemau_rsp_t   (one response)
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// The byte store is organized as 64-bit rows, and a request touches at
// most two adjacent rows, one row access per cycle on the single RAM port.
// The response is loaded into the output register at the edge that leaves
// FIN, after ROW1; the next request is accepted at that same edge. When the
// output register is still full and not being taken, the unit holds in its
// final state with s_ready low. Reset is synchronous and active low; it
// clears the control state, the fault record and the configuration, but
// not the byte store. cfg_ready is always high.
// ----------------------------------------------------------------------------
module big_endian_memory_access_unit_core #(
    parameter int MEM_BYTES = 65536
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Request channel.
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  bemau_pkg::bemau_req_t                 s_data,
    // Response channel.
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output bemau_pkg::bemau_rsp_t                 m_data,
    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [bemau_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bemau_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    import bemau_pkg::*;

    // The store is kept as rows of eight bytes; byte n of a row sits in
    // lane n, bits [8n+7:8n].
    localparam int ROWS   = (MEM_BYTES + 7) / 8;
    localparam int ROW_AW = $clog2(ROWS);

    // Configuration registers.
    logic [16:0] memory_limit_reg;
    logic [2:0]  cpu_model_major_reg;

    // Fault record.
    logic        last_fault_read_reg;
    logic [31:0] last_fault_addr_reg;

    // Sequencer.
    bemau_state_t state_reg, state_next;

    // Per-request context kept for the second beat and the response.
    logic [2:0]        p_off_reg;
    logic [2:0]        p_len_m1_reg;
    logic              p_rd_reg;
    logic              p_fault_reg;
    logic              p_row1_en_reg;
    logic [ROW_AW-1:0] p_row1_reg;
    logic [7:0]        p_wbe1_reg;
    logic [63:0]       p_wdata1_reg;
    logic [63:0]       row0_data_reg;

    // Output register.
    logic        m_valid_reg;
    bemau_rsp_t  m_data_reg;

    // RAM port.
    logic              ram_en;
    logic [7:0]        ram_wbe;
    logic [ROW_AW-1:0] ram_addr;
    logic [63:0]       ram_wdata;
    logic [63:0]       ram_rdata;

    // Request decode, evaluated on the incoming payload.
    logic              accept;
    logic              out_free;
    logic              load_out;
    logic              req_write;
    logic [2:0]        len_m1;
    logic [2:0]        off;
    logic              fault;
    logic [32:0]       last_byte;
    logic [32:0]       eff_limit;
    logic              do_access;
    logic              spans;
    logic [ROW_AW-1:0] row0;
    logic [127:0]      wr_window;
    logic [15:0]       wr_be;
    logic [63:0]       rd_bytes;
    logic [63:0]       rd_value;
    bemau_rsp_t        rsp;

    assign accept    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Decode of the request at the input. The range check runs on the
    // span computed one bit wider, so that a span that wraps past the top
    // of the 32-bit address space counts as out of range.
    // ------------------------------------------------------------------
    assign req_write = (s_data.req_type == REQ_WRITE);
    assign len_m1    = 3'((4'h1 << s_data.access_size) - 4'h1);
    assign off       = s_data.address[2:0];
    assign fault     = (s_data.access_size != SIZE_BYTE) && s_data.address[0]
                       && (cpu_model_major_reg < CPU_ODD_OK_MIN);
    assign last_byte = {1'b0, s_data.address} + 33'(len_m1);
    assign eff_limit = (33'(memory_limit_reg) > 33'(MEM_BYTES)) ? 33'(MEM_BYTES)
                                                                  : 33'(memory_limit_reg);
    assign do_access = !fault && (last_byte < eff_limit);
    assign spans     = (4'({1'b0, off}) + 4'({1'b0, len_m1})) > 4'd7;
    assign row0      = s_data.address[ROW_AW+2:3];

    // The right-aligned write data is byte swapped so that its first byte
    // lands in the lowest lane, then shifted up to the start offset in a
    // two-row window. The same shift places the byte enables.
    assign wr_window = {64'h0, byte_swap64(s_data.write_data) >> {~len_m1, 3'b000}}
                       << {off, 3'b000};
    assign wr_be     = {8'h00, 8'hFF >> ~len_m1} << off;

    // ------------------------------------------------------------------
    // Sequencer: accept and first row together in IDLE or FIN, second row
    // in ROW1, assembly and response load in FIN.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    state_next = ST_ROW1;
                end
            end
            ST_ROW1: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                s_ready  = out_free;
                load_out = out_free;
                if (out_free) begin
                    state_next = s_valid ? ST_ROW1 : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // RAM port. The second row goes out in ROW1; otherwise an accepted
    // request issues its first row right away. Faulting and out-of-range
    // requests leave the store untouched.
    // ------------------------------------------------------------------
    always_comb begin
        ram_en    = 1'b0;
        ram_wbe   = '0;
        ram_addr  = row0;
        ram_wdata = wr_window[63:0];
        if (state_reg == ST_ROW1) begin
            ram_en    = p_row1_en_reg;
            ram_wbe   = p_wbe1_reg;
            ram_addr  = p_row1_reg;
            ram_wdata = p_wdata1_reg;
        end else if (accept) begin
            ram_en  = do_access;
            ram_wbe = req_write ? wr_be[7:0] : 8'h00;
        end
    end

    bemau_ram #(
        .WIDTH (64),
        .DEPTH (ROWS)
    ) u_ram (
        .aclk  (aclk),
        .en    (ram_en),
        .wbe   (ram_wbe),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Request context; payload only, no reset needed.
    always_ff @(posedge aclk) begin
        if (accept) begin
            p_off_reg     <= off;
            p_len_m1_reg  <= len_m1;
            p_rd_reg      <= do_access && !req_write;
            p_fault_reg   <= fault;
            p_row1_en_reg <= do_access && spans;
            p_row1_reg    <= row0 + ROW_AW'(1);
            p_wbe1_reg    <= req_write ? wr_be[15:8] : 8'h00;
            p_wdata1_reg  <= wr_window[127:64];
        end
        if (state_reg == ST_ROW1) begin
            row0_data_reg <= ram_rdata;
        end
    end

    // ------------------------------------------------------------------
    // Read assembly: the two rows form a window, the bytes from the start
    // offset are taken in lane order, swapped back to big-endian order and
    // right aligned. Lanes past the access length fall off the shift.
    // Rows that were not read only feed lanes that are discarded.
    // ------------------------------------------------------------------
    assign rd_bytes = 64'({ram_rdata, row0_data_reg} >> {p_off_reg, 3'b000});
    assign rd_value = byte_swap64(rd_bytes) >> {~p_len_m1_reg, 3'b000};

    always_comb begin
        rsp                = '0;
        rsp.read_data      = p_rd_reg ? rd_value : 64'h0;
        rsp.address_error  = p_fault_reg;
        rsp.fault_was_read = last_fault_read_reg;
        rsp.fault_address  = last_fault_addr_reg;
    end

    // Output register. The fault record read here already holds this
    // request's own update; a request accepted at the same edge updates it
    // only afterwards.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_data_reg <= rsp;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Fault record, updated at acceptance of a faulting request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_fault_read_reg <= 1'b0;
            last_fault_addr_reg <= '0;
        end else if (accept && fault) begin
            last_fault_read_reg <= !req_write;
            last_fault_addr_reg <= s_data.address;
        end
    end

    // Configuration registers. Indexes outside the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            memory_limit_reg    <= MEMORY_LIMIT_RST;
            cpu_model_major_reg <= CPU_MODEL_MAJOR_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_MEMORY_LIMIT: begin
                    memory_limit_reg <= cfg_wdata;
                end
                CFG_CPU_MODEL_MAJOR: begin
                    cpu_model_major_reg <= cfg_wdata[2:0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- rtl/bemau_checker.sv -----
// ----------------------------------------------------------------------------
// bemau_checker: port-level checks for the big-endian memory access unit
// Watches the response channel, checks that a stalled response holds and checks properties of faulting responses.
// ----------------------------------------------------------------------------
module bemau_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  bemau_pkg::bemau_rsp_t             m_data
);

    import bemau_pkg::*;

    // A stalled response holds.
    a_rsp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("response changed while stalled");

    // A faulting request never returns data.
    a_fault_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.address_error |-> m_data.read_data == 64'h0)
        else $error("address error response carries read data");

    // Address errors only come from odd addresses, and the record shows it.
    a_fault_addr_odd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.address_error |-> m_data.fault_address[0])
        else $error("address error recorded at an even address");

endmodule

bind big_endian_memory_access_unit_core bemau_checker u_bemau_checker (.*);
